// File: rtl/pss_pkg.sv
package pss_pkg;

   // widths fixed by the item formats
   localparam int VALUE_W   = 32;
   localparam int OUT_IDX_W = 10;

   // one pair test and its outcome
   typedef struct packed {
      logic                       hit;
      logic signed [VALUE_W:0]    sum;
   } pair_res_type;

endpackage

// File: rtl/pss_pair_cmp.sv
module pss_pair_cmp (
   input  logic signed [pss_pkg::VALUE_W-1:0] first_val,
   input  logic signed [pss_pkg::VALUE_W-1:0] second_val,
   input  logic signed [pss_pkg::VALUE_W-1:0] target_val,
   output pss_pkg::pair_res_type              res
);
   import pss_pkg::*;

   logic signed [VALUE_W:0] sum_wide;
   logic signed [VALUE_W:0] target_wide;

   // exact sum one bit wider than the operands, so it never wraps
   assign sum_wide    = {first_val[VALUE_W-1], first_val}
                      + {second_val[VALUE_W-1], second_val};
   assign target_wide = {target_val[VALUE_W-1], target_val};

   assign res.sum = sum_wide;
   assign res.hit = (sum_wide == target_wide);

endmodule

// File: rtl/pair_sum_search_top.sv
// pair sum search
// req channel: one list element per item, req_tdata holds the signed value and
// req_tlast marks the final element, which starts the search. elements load at
// one item per cycle; items beyond MAX_ITEMS are dropped and flagged.
// csr port: csr_we with csr_wdata writes the signed target sum (reset 0).
// rsp channel: exactly one item after each last item, giving found, the two
// indices (low 10 bits) and the overflow flag.
// search: one shared 33-bit add and compare tests one pair per cycle, reading
// the element store through its single registered read port. for each first
// index i the states RDA and WA fetch element i, then CMP tests each later index.
// a hit stops at the pair found. req_tready is low for the whole search.
// the result sits in an output register; the next list may load while it waits,
// and a second search only holds at its end until rsp_tready takes the first.
// reset (synchronous, active high) empties the list, clears the flag, drops any
// pending result and sets the target to zero. the store needs no clearing.
module pair_sum_search_top #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: value[31:0]
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [pss_pkg::VALUE_W-1:0]   req_tdata,
   input  logic                          req_tlast,
   // rsp_tdata: first_index[9:0], second_index[19:10], zero fill [23:20]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata,
   // rsp_tuser: found[0], overflowed[1]
   output logic [1:0]                    rsp_tuser,
   input  logic                          csr_we,
   input  logic [pss_pkg::VALUE_W-1:0]   csr_wdata
);
   import pss_pkg::*;

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int IW = $clog2(MAX_ITEMS);
   localparam int PW = (IW > OUT_IDX_W) ? IW : OUT_IDX_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RDA  = 3'd1;
   localparam logic [2:0] ST_WA   = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [VALUE_W-1:0]   target_ff, target_in;
   logic [IW-1:0]        i_ff, i_in;
   logic [IW-1:0]        j_ff, j_in;
   logic [VALUE_W-1:0]   a_ff, a_in;
   logic                 hit_ff, hit_in;
   logic [IW-1:0]        fi_ff, fi_in;
   logic [IW-1:0]        si_ff, si_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;
   logic [OUT_IDX_W-1:0] rsp_fi_ff, rsp_fi_in;
   logic [OUT_IDX_W-1:0] rsp_si_ff, rsp_si_in;

   logic [VALUE_W-1:0]   mem [MAX_ITEMS];
   logic [VALUE_W-1:0]   rd_data_ff;
   logic [IW-1:0]        rd_addr;
   logic                 wr_en;
   logic                 req_acc;
   logic                 room;
   logic [CW-1:0]        n_after;
   logic [PW-1:0]        fi_pad;
   logic [PW-1:0]        si_pad;
   pair_res_type         cmp_res;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign room       = (count_ff < CW'(MAX_ITEMS));
   assign wr_en      = req_acc && room;
   assign n_after    = room ? (count_ff + CW'(1)) : count_ff;

   // element store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IW-1:0]] <= req_tdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // read address: element i when fetching the first operand, else the next j
   always_comb begin
      if (state_ff == ST_RDA) begin
         rd_addr = i_ff;
      end else if (state_ff == ST_WA) begin
         rd_addr = i_ff + IW'(1);
      end else begin
         rd_addr = j_ff + IW'(1);
      end
   end

   // shared pair test
   pss_pair_cmp u_cmp (
      .first_val  (a_ff),
      .second_val (rd_data_ff),
      .target_val (target_ff),
      .res        (cmp_res)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      target_in    = target_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      a_in         = a_ff;
      hit_in       = hit_ff;
      fi_in        = fi_ff;
      si_in        = si_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_fi_in    = rsp_fi_ff;
      rsp_si_in    = rsp_si_ff;

      if (csr_we) begin
         target_in = csr_wdata;
      end

      // result taken by the receiver
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               count_in = n_after;
               if (!room) begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  hit_in = 1'b0;
                  fi_in  = '0;
                  si_in  = '0;
                  i_in   = '0;
                  if (n_after >= CW'(2)) begin
                     state_in = ST_RDA;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_RDA: begin
            state_in = ST_WA;
         end
         ST_WA: begin
            // first operand arrives, second operand starts at i + 1
            a_in     = rd_data_ff;
            j_in     = i_ff + IW'(1);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (cmp_res.hit) begin
               hit_in   = 1'b1;
               fi_in    = i_ff;
               si_in    = j_ff;
               state_in = ST_DONE;
            end else if ((CW'(j_ff) + CW'(1)) == count_ff) begin
               // last second index for this i
               if ((CW'(i_ff) + CW'(2)) >= count_ff) begin
                  state_in = ST_DONE;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_RDA;
               end
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         ST_DONE: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_fi_in    = fi_pad[OUT_IDX_W-1:0];
               rsp_si_in    = si_pad[OUT_IDX_W-1:0];
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign fi_pad = PW'(fi_ff);
   assign si_pad = PW'(si_ff);

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      a_ff         <= a_in;
      hit_ff       <= hit_in;
      fi_ff        <= fi_in;
      si_ff        <= si_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_fi_ff    <= rsp_fi_in;
      rsp_si_ff    <= rsp_si_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_si_ff, rsp_fi_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_found_ff};

endmodule

// File: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pss_pkg::*;

   localparam int MAX_ITEMS  = 1024;
   localparam int IDLE_LIMIT = 20000;

   // one list element as it goes on the req channel
   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               last;
   } element_item_type;

   // one search outcome as it comes on the rsp channel
   typedef struct packed {
      logic                 found;
      logic [OUT_IDX_W-1:0] first_idx;
      logic [OUT_IDX_W-1:0] second_idx;
      logic                 dropped;
   } pair_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [VALUE_W-1:0] req_tdata  = '0;
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [23:0]        rsp_tdata;
   logic [1:0]         rsp_tuser;
   logic               csr_we     = 1'b0;
   logic [VALUE_W-1:0] csr_wdata  = '0;

   // items waiting for the driver, results waiting for the monitor
   element_item_type pending_elements[$];
   pair_result_type  expected_pairs[$];
   int items_total    = 0;
   int items_accepted = 0;
   int err_count      = 0;
   int result_count   = 0;

   // own copy of the block state
   logic signed [VALUE_W-1:0] element_mem [MAX_ITEMS];
   int                        element_cnt = 0;
   logic                      dropped_flag = 1'b0;
   logic signed [VALUE_W-1:0] target_copy = '0;

   pair_sum_search_top #(
      .MAX_ITEMS(MAX_ITEMS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch on result %0d: %s got %0d want %0d",
               $realtime, result_count, what, got, want);
      err_count++;
   endtask

   // first pair i < j in scan order whose exact sum hits the target
   function automatic pair_result_type search_pairs();
      pair_result_type r;
      r = '0;
      for (int i = 0; i < element_cnt && !r.found; i++) begin
         for (int j = i + 1; j < element_cnt && !r.found; j++) begin
            if (longint'(element_mem[i]) + longint'(element_mem[j]) ==
                longint'(target_copy)) begin
               r.found      = 1'b1;
               r.first_idx  = i[OUT_IDX_W-1:0];
               r.second_idx = j[OUT_IDX_W-1:0];
            end
         end
      end
      r.dropped = dropped_flag;
      return r;
   endfunction

   // store or drop one accepted element; a last item yields one result
   function automatic void accept_element(input logic [VALUE_W-1:0] v, input logic lst);
      if (element_cnt < MAX_ITEMS) begin
         element_mem[element_cnt] = v;
         element_cnt++;
      end else begin
         dropped_flag = 1'b1;
      end
      if (lst) begin
         expected_pairs.push_back(search_pairs());
         element_cnt  = 0;
         dropped_flag = 1'b0;
      end
   endfunction

   // driver: bursts of random length with random gaps
   int burst_left = 1;
   int gap_left   = 0;
   always @(posedge clock) begin
      element_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(1, 32);
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            accept_element(req_tdata, req_tlast);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_elements.size() != 0) begin
               nxt = pending_elements.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.value;
               req_tlast  <= nxt.last;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result, stall on a mode pattern of its own
   int stall_mode = 0;
   int mode_left  = 0;
   int mode_tick  = 0;
   always @(posedge clock) begin
      pair_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (expected_pairs.size() == 0) begin
               report_mismatch("result with none expected", rsp_tdata, 0);
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_tuser[0] !== want.found)
                  report_mismatch("found", rsp_tuser[0], want.found);
               if (rsp_tdata[9:0] !== want.first_idx)
                  report_mismatch("first_index", rsp_tdata[9:0], want.first_idx);
               if (rsp_tdata[19:10] !== want.second_idx)
                  report_mismatch("second_index", rsp_tdata[19:10], want.second_idx);
               if (rsp_tuser[1] !== want.dropped)
                  report_mismatch("overflowed", rsp_tuser[1], want.dropped);
               if (rsp_tdata[23:20] !== 4'b0)
                  report_mismatch("tdata fill", rsp_tdata[23:20], 0);
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         mode_tick++;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= (mode_tick % 4 == 0);
            default: rsp_tready <= 1'b0;
         endcase
      end
   end

   // watchdog on cycles with no handshake on either channel
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_item(input logic [VALUE_W-1:0] v, input logic lst);
      element_item_type it;
      it.value = v;
      it.last  = lst;
      pending_elements.push_back(it);
      items_total++;
   endtask

   // wait until every item is in and every result is out
   task automatic wait_idle();
      while (items_accepted != items_total || expected_pairs.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_target(input logic signed [VALUE_W-1:0] t);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= t;
      @(posedge clock);
      csr_we      <= 1'b0;
      target_copy = t;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value(input int style,
                                                           input logic signed [VALUE_W-1:0] t);
      logic signed [VALUE_W-1:0] v;
      case (style)
         0: v = $urandom;
         1: v = (t >>> 1) + (int'($urandom_range(0, 8)) - 4);
         2: begin
            case ($urandom_range(0, 5))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               3: v = 32'hFFFF_FFFF;
               4: v = 32'h0000_0001;
               default: v = t;
            endcase
         end
         default: v = int'($urandom_range(0, 15)) - 8;
      endcase
      return v;
   endfunction

   // one list of len elements, optionally with a pair planted on the target
   task automatic push_list(input int len, input int style, input bit plant);
      logic signed [VALUE_W-1:0] vals[$];
      logic signed [VALUE_W-1:0] a;
      longint                    b;
      int                        p;
      int                        q;
      for (int k = 0; k < len; k++)
         vals.push_back(pick_value(style, target_copy));
      if (plant && len >= 2) begin
         if (len > MAX_ITEMS) begin
            p = 0;
            q = MAX_ITEMS - 1;
         end else begin
            p = $urandom_range(0, len - 2);
            q = $urandom_range(p + 1, len - 1);
         end
         a = $urandom;
         b = longint'(target_copy) - longint'(a);
         if (b > 64'sd2147483647 || b < -64'sd2147483648) begin
            a = target_copy >>> 1;
            b = longint'(target_copy) - longint'(a);
         end
         vals[p] = a;
         vals[q] = b[VALUE_W-1:0];
      end
      for (int k = 0; k < len; k++)
         push_item(vals[k], k == len - 1);
   endtask

   initial begin : stimulus
      logic signed [VALUE_W-1:0] t;
      int                        len;
      int                        phase_items;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // target still at its reset value of zero; single element must not self pair
      push_item(32'd5, 1'b0);
      push_item(-32'sd5, 1'b1);
      push_item(32'd0, 1'b1);
      wait_idle();

      // max plus max wraps to -2 but the exact sum does not match
      set_target(-32'sd2);
      push_item(32'h7FFF_FFFF, 1'b0);
      push_item(32'h7FFF_FFFF, 1'b0);
      push_item(32'hFFFF_FFFF, 1'b0);
      push_item(32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // most negative target reached exactly
      set_target(32'sh8000_0000);
      push_item(32'd3, 1'b0);
      push_item(32'hC000_0000, 1'b0);
      push_item(32'h8000_0000, 1'b0);
      push_item(32'hC000_0000, 1'b0);
      push_item(32'd0, 1'b1);
      wait_idle();

      // most positive target: the wrapped pair must miss, the exact one hit
      set_target(32'sh7FFF_FFFF);
      push_item(32'h8000_0000, 1'b0);
      push_item(32'hFFFF_FFFF, 1'b1);
      push_item(32'h7FFF_FFFF, 1'b0);
      push_item(32'd0, 1'b1);
      wait_idle();

      // 5 would pair with itself for 10; only later indices count
      set_target(32'sd10);
      push_item(32'd5, 1'b0);
      push_item(32'd3, 1'b0);
      push_item(32'd7, 1'b1);
      push_item(32'd5, 1'b1);
      wait_idle();

      // random lists under a range of targets
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: t = 32'sh8000_0000;
            1: t = 32'sh7FFF_FFFF;
            2: t = 32'sd0;
            4: t = int'($urandom_range(0, 40)) - 20;
            5: t = -32'sd1;
            default: t = $urandom;
         endcase
         set_target(t);
         // one list past capacity, dropped last item, pair at the far end
         if (ph == 3)
            push_list(MAX_ITEMS + int'($urandom_range(1, 4)), $urandom_range(0, 3), 1'b1);
         phase_items = 0;
         while (phase_items < 52) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
            push_list(len, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
            phase_items += len;
         end
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
